@@ rtl/range_bitmap_set_and_test_macros.svh @@
// assertion helpers for the range bitmap block
`ifndef RANGE_BITMAP_SET_AND_TEST_MACROS_SVH
`define RANGE_BITMAP_SET_AND_TEST_MACROS_SVH

// same-cycle implication, held off during reset
`define RBST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define RBST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rbst_pkg.sv @@
`default_nettype none

package rbst_pkg;

   localparam int MAP_BITS_DEF = 1024;
   localparam int WORD_BITS    = 32;
   localparam int OFFSET_W     = 5;
   localparam int SIZE_W       = 11;
   localparam int INDEX_W      = 16;
   localparam int WORD_IDX_W   = SIZE_W - OFFSET_W;
   localparam int CMD_W        = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET        = 2'd0,
      CMD_TEST_SET   = 2'd1,
      CMD_TEST_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_MODIFY,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ rtl/range_bitmap_set_and_test.sv @@
// flow: a taken item goes through check and then finish for an empty or rejected range, otherwise
//   through check, read and a modify step per 32-bit word the range covers (up to 32), then finish
// throughput: one item at a time, one store word per cycle in the modify steps, and finish waits for a free
//   response slot; the next item is taken the cycle after the result is registered
// reset: map_size returns to 1024 and a clearing pass writes zero to every word,
//   during which no item is taken
`default_nettype none

`include "range_bitmap_set_and_test_macros.svh"

module range_bitmap_set_and_test #(
   parameter int MAP_BITS = rbst_pkg::MAP_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [rbst_pkg::SIZE_W-1:0]  csr_map_size,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [rbst_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [rbst_pkg::INDEX_W-1:0] req_start_index,
   input  wire logic [rbst_pkg::INDEX_W-1:0] req_bit_count,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_answer
);

   import rbst_pkg::*;

   localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   state_type                 state_ff, state_in;
   logic [AW-1:0]             clr_addr_ff, clr_addr_in;
   logic [SIZE_W-1:0]         map_size_ff;
   cmd_type                   cmd_ff;
   logic [INDEX_W-1:0]        start_ff;
   logic [INDEX_W-1:0]        count_ff;
   logic [WORD_IDX_W-1:0]     first_word_ff, first_word_in;
   logic [WORD_IDX_W-1:0]     last_word_ff, last_word_in;
   logic [OFFSET_W-1:0]       lo_ff, lo_in;
   logic [OFFSET_W-1:0]       hi_ff, hi_in;
   logic [WORD_IDX_W-1:0]     word_ff, word_in;
   logic                      answer_ff, answer_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_answer_ff, rsp_answer_in;

   logic [SIZE_W-1:0]         size;
   logic [INDEX_W:0]          range_end;
   logic                      start_ok;
   logic                      fits;
   logic [SIZE_W-1:0]         end_bit;
   logic [SIZE_W-1:0]         last_bit;
   logic                      active;
   logic                      is_test;
   logic                      slot_free;
   logic [OFFSET_W-1:0]       word_lo;
   logic [OFFSET_W-1:0]       word_hi;
   logic [WORD_BITS-1:0]      mask;
   logic [WORD_BITS-1:0]      hit;
   logic                      word_ok;

   logic                      ram_we;
   logic [AW-1:0]             ram_wr_addr;
   logic [WORD_BITS-1:0]      ram_wr_data;
   logic [AW-1:0]             ram_rd_addr;
   logic [WORD_BITS-1:0]      ram_rd_data;

   rbst_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // size in use and range bounds
   always_comb begin
      if (17'(map_size_ff) > 17'(MAP_BITS)) begin
         size = SIZE_W'(MAP_BITS);
      end else begin
         size = map_size_ff;
      end
      start_ok  = start_ff < INDEX_W'(size);
      range_end = (INDEX_W+1)'(start_ff) + (INDEX_W+1)'(count_ff);
      fits      = range_end <= (INDEX_W+1)'(size);
      end_bit   = fits ? range_end[SIZE_W-1:0] : size;
      last_bit  = end_bit - SIZE_W'(1);
      is_test   = (cmd_ff == CMD_TEST_SET) || (cmd_ff == CMD_TEST_CLEAR);
      case (cmd_ff)
         CMD_SET:        active = (count_ff != '0) && start_ok;
         CMD_TEST_SET:   active = (count_ff != '0) && start_ok && fits;
         CMD_TEST_CLEAR: active = (count_ff != '0) && start_ok && fits;
         default:        active = 1'b0;
      endcase
   end

   // bits of the current word inside the range
   always_comb begin
      word_lo = (word_ff == first_word_ff) ? lo_ff : '0;
      word_hi = (word_ff == last_word_ff) ? hi_ff : OFFSET_W'(WORD_BITS - 1);
      mask    = ({WORD_BITS{1'b1}} << word_lo)
              & ({WORD_BITS{1'b1}} >> (OFFSET_W'(WORD_BITS - 1) - word_hi));
      hit     = ram_rd_data & mask;
      word_ok = (cmd_ff == CMD_TEST_SET) ? (hit == mask) : (hit == '0);
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      first_word_in = first_word_ff;
      last_word_in  = last_word_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      word_in       = word_ff;
      answer_in     = answer_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_answer_in = rsp_answer_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = AW'(word_ff);
      ram_wr_data   = ram_rd_data | mask;
      ram_rd_addr   = AW'(word_ff);
      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            first_word_in = start_ff[SIZE_W-1:OFFSET_W];
            last_word_in  = last_bit[SIZE_W-1:OFFSET_W];
            lo_in         = start_ff[OFFSET_W-1:0];
            hi_in         = last_bit[OFFSET_W-1:0];
            word_in       = start_ff[SIZE_W-1:OFFSET_W];
            answer_in     = 1'b0;
            state_in      = active ? ST_READ : ST_FINISH;
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            ram_rd_addr = AW'(word_ff + WORD_IDX_W'(1));
            ram_we      = (cmd_ff == CMD_SET);
            if ((word_ff == last_word_ff) || (is_test && !word_ok)) begin
               answer_in = is_test && word_ok;
               state_in  = ST_FINISH;
            end else begin
               word_in = word_ff + WORD_IDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = answer_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         map_size_ff  <= SIZE_W'(MAP_BITS_DEF);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            map_size_ff <= csr_map_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff   <= cmd_type'(req_cmd);
         start_ff <= req_start_index;
         count_ff <= req_bit_count;
      end
      first_word_ff <= first_word_in;
      last_word_ff  <= last_word_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      word_ff       <= word_in;
      answer_ff     <= answer_in;
      rsp_answer_ff <= rsp_answer_in;
   end

   `RBST_ASSERT_NOW(a_no_transfer_in_clear, clock, reset, (state_ff == ST_CLEAR), (!req_ready), "item taken during clearing pass")

   `RBST_ASSERT_NOW(a_write_only_clear_or_set, clock, reset, ram_we, ((state_ff == ST_CLEAR) || ((state_ff == ST_MODIFY) && (cmd_ff == CMD_SET))), "store written outside a clear or set")

   `RBST_ASSERT_NOW(a_word_in_range, clock, reset, (state_ff == ST_MODIFY), ((word_ff >= first_word_ff) && (word_ff <= last_word_ff)), "walk left the range")

   `RBST_ASSERT_NEXT(a_result_after_finish, clock, reset, ((state_ff == ST_FINISH) && slot_free), (rsp_valid_ff && (state_ff == ST_IDLE)), "finished item not presented")

endmodule

`default_nettype wire

@@ rtl/rbst_ram.sv @@
`default_nettype none

module rbst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
